// File: rtl/rle_enc_pkg.sv
// Shared types and constants for the byte run-length encoder.
// Used by every module under rtl/; depends on nothing.
`default_nettype none

package rle_enc_pkg;

    localparam int BYTE_W     = 8;
    localparam int RUN_LEN_W  = 8;
    localparam int LEN_W      = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Word index of the budget register (byte address 4 * index).
    localparam logic [0:0] REG_OUTPUT_BUDGET = 1'b0;

    localparam logic [LEN_W-1:0] BUDGET_RESET = 16'd256;
    localparam logic [LEN_W-1:0] PAIR_BYTES   = 16'd2;

    // One accepted byte as seen by the back end: an optional closed run and an
    // optional final flush. An entry always carries at least one of the two.
    typedef struct packed {
        logic                 has_close;
        logic [BYTE_W-1:0]    close_value;
        logic [RUN_LEN_W-1:0] close_count;
        logic                 has_fin;
        logic [BYTE_W-1:0]    fin_value;
        logic [RUN_LEN_W-1:0] fin_count;
    } t_run_op;

    // Handshake between queue and back end.
    typedef struct packed {
        logic valid;
        logic pop;
    } t_q_ctl;

endpackage

`default_nettype wire

// File: rtl/rle_enc_cfg.sv
// APB-style register slave holding the output budget register.
// Depends on rle_enc_pkg.
`default_nettype none

module rle_enc_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rle_enc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [rle_enc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [rle_enc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                     pready,
    output logic      [rle_enc_pkg::LEN_W-1:0]       o_budget
);

    logic [rle_enc_pkg::LEN_W-1:0] r_budget;
    logic                          sel_budget;

    assign sel_budget = (paddr[2] == rle_enc_pkg::REG_OUTPUT_BUDGET);
    assign pready     = 1'b1;
    assign o_budget   = r_budget;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= rle_enc_pkg::BUDGET_RESET;
        end else if (psel && penable && pwrite && sel_budget) begin
            r_budget <= pwdata[rle_enc_pkg::LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_budget) begin
            prdata = rle_enc_pkg::CFG_DATA_W'(r_budget);
        end
    end

endmodule

`default_nettype wire

// File: rtl/rle_enc_front.sv
// Front end: tracks the open run; queues each byte that closes a run or ends a message.
// Depends on rle_enc_pkg.
`default_nettype none

module rle_enc_front #(
    parameter int MAX_RUN = 255
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [rle_enc_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire logic                            i_final_byte,
    input  wire logic                            i_q_full,
    output logic                                 o_q_push,
    output rle_enc_pkg::t_run_op                 o_q_entry
);

    localparam int CNT_W = $clog2(MAX_RUN + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RUN);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    logic [rle_enc_pkg::BYTE_W-1:0] r_run_byte;
    logic [CNT_W-1:0]               r_run_count;
    logic [rle_enc_pkg::BYTE_W-1:0] n_run_byte;
    logic [CNT_W-1:0]               n_run_count;

    logic accept;
    logic run_open;
    logic close_run;
    logic start_run;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign run_open   = (r_run_count != '0);
    assign close_run  = run_open && ((i_data_byte != r_run_byte) || (r_run_count >= MAX_CNT));
    assign start_run  = close_run || !run_open;

    always_comb begin
        n_run_byte  = start_run ? i_data_byte : r_run_byte;
        n_run_count = start_run ? ONE_CNT : (r_run_count + ONE_CNT);

        o_q_entry.has_close   = close_run;
        o_q_entry.close_value = r_run_byte;
        o_q_entry.close_count = rle_enc_pkg::RUN_LEN_W'(r_run_count);
        o_q_entry.has_fin     = i_final_byte;
        o_q_entry.fin_value   = n_run_byte;
        o_q_entry.fin_count   = rle_enc_pkg::RUN_LEN_W'(n_run_count);

        // Bytes that only extend the run need no back-end work.
        o_q_push = accept && (close_run || i_final_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_byte  <= '0;
            r_run_count <= '0;
        end else if (accept) begin
            if (i_final_byte) begin
                r_run_byte  <= '0;
                r_run_count <= '0;
            end else begin
                r_run_byte  <= n_run_byte;
                r_run_count <= n_run_count;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/rle_enc_queue.sv
// Short FIFO of run operations between front and back end.
// Depends on rle_enc_pkg.
`default_nettype none

module rle_enc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire rle_enc_pkg::t_run_op  i_entry,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output logic                       o_valid,
    output rle_enc_pkg::t_run_op       o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    rle_enc_pkg::t_run_op r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : (r_wr_ptr + PTR_W'(1));
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : (r_rd_ptr + PTR_W'(1));
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> (r_count == DEPTH_CNT) || (r_count == DEPTH_CNT - CNT_W'(1)))
        else $error("queue overran while full");

    a_entry_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry.has_close || o_entry.has_fin))
        else $error("empty operation in queue");

endmodule

`default_nettype wire

// File: rtl/rle_enc_back.sv
// Back end: budget accounting, overflow suppression and the output register.
// Depends on rle_enc_pkg.
`default_nettype none

module rle_enc_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [rle_enc_pkg::LEN_W-1:0]      i_budget,
    input  wire rle_enc_pkg::t_run_op               i_q_entry,
    input  wire logic                               i_q_valid,
    output rle_enc_pkg::t_q_ctl                     o_q_ctl,
    input  wire logic                               i_out_stall,
    output logic                                    o_out_valid,
    output logic      [rle_enc_pkg::BYTE_W-1:0]     o_run_value,
    output logic      [rle_enc_pkg::RUN_LEN_W-1:0]  o_run_length,
    output logic      [rle_enc_pkg::LEN_W-1:0]      o_encoded_length,
    output logic                                    o_overflow,
    output logic                                    o_last
);

    localparam int LEN_W = rle_enc_pkg::LEN_W;

    logic [LEN_W-1:0] r_used;
    logic             r_ovf;
    logic             r_phase;   // 1: close half of the entry is done
    logic [LEN_W-1:0] n_used;
    logic             n_ovf;
    logic             n_phase;

    logic                                r_out_valid;
    logic [rle_enc_pkg::BYTE_W-1:0]      r_out_value;
    logic [rle_enc_pkg::RUN_LEN_W-1:0]   r_out_len;
    logic [LEN_W-1:0]                    r_out_enc;
    logic                                r_out_ovf;
    logic                                r_out_last;

    logic                                emit;
    logic [rle_enc_pkg::BYTE_W-1:0]      emit_value;
    logic [rle_enc_pkg::RUN_LEN_W-1:0]   emit_len;
    logic [LEN_W-1:0]                    emit_enc;
    logic                                emit_ovf;

    logic                                out_free;
    logic                                step;
    logic                                op_close;
    logic                                op_last;
    logic [rle_enc_pkg::BYTE_W-1:0]      op_value;
    logic [rle_enc_pkg::RUN_LEN_W-1:0]   op_count;
    logic                                fits;
    logic [LEN_W-1:0]                    sum_used;
    logic                                pop;

    assign out_free = !r_out_valid || !i_out_stall;
    assign step     = i_q_valid && out_free;
    assign op_close = !r_phase && i_q_entry.has_close;
    assign op_last  = !op_close;
    assign op_value = op_close ? i_q_entry.close_value : i_q_entry.fin_value;
    assign op_count = op_close ? i_q_entry.close_count : i_q_entry.fin_count;
    assign fits     = ({1'b0, r_used} + {1'b0, rle_enc_pkg::PAIR_BYTES}) <= {1'b0, i_budget};
    assign sum_used = r_used + rle_enc_pkg::PAIR_BYTES;

    always_comb begin
        n_used     = r_used;
        n_ovf      = r_ovf;
        n_phase    = r_phase;
        emit       = 1'b0;
        emit_value = op_value;
        emit_len   = op_count;
        emit_enc   = sum_used;
        emit_ovf   = 1'b0;
        pop        = 1'b0;
        if (step) begin
            if (!r_ovf && fits) begin
                n_used = sum_used;
                emit   = 1'b1;
            end else begin
                // Pair dropped; the message ends in one overflow item.
                n_ovf = 1'b1;
                if (op_last) begin
                    emit       = 1'b1;
                    emit_value = '0;
                    emit_len   = '0;
                    emit_enc   = r_used;
                    emit_ovf   = 1'b1;
                end
            end
            if (op_last) begin
                n_used  = '0;
                n_ovf   = 1'b0;
                n_phase = 1'b0;
                pop     = 1'b1;
            end else if (i_q_entry.has_fin) begin
                n_phase = 1'b1;
            end else begin
                pop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_ovf       <= 1'b0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_used  <= n_used;
            r_ovf   <= n_ovf;
            r_phase <= n_phase;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_value <= emit_value;
            r_out_len   <= emit_len;
            r_out_enc   <= emit_enc;
            r_out_ovf   <= emit_ovf;
            r_out_last  <= op_last;
        end
    end

    assign o_q_ctl.valid    = i_q_valid;
    assign o_q_ctl.pop      = pop;
    assign o_out_valid      = r_out_valid;
    assign o_run_value      = r_out_value;
    assign o_run_length     = r_out_len;
    assign o_encoded_length = r_out_enc;
    assign o_overflow       = r_out_ovf;
    assign o_last           = r_out_last;

    a_pair_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ovf) |-> (r_out_len != '0))
        else $error("pair item with zero run length");

    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |-> (r_out_last && r_out_len == '0))
        else $error("overflow item not final");

    a_pair_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ovf) |-> (r_out_enc <= i_budget))
        else $error("pair item beyond budget");

    a_used_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used[0] == 1'b0)
        else $error("odd byte count");

endmodule

`default_nettype wire

// File: rtl/rle_byte_run_encoder_unit.sv
// Top level of the byte run-length encoder: front end, op queue, back end,
// register slave. Depends on rle_enc_pkg and the rle_enc_* modules.
//
//   channel  | direction | handshake               | payload
//   in       | input     | i_in_valid / o_in_stall | i_data_byte, i_final_byte
//   out      | output    | o_out_valid/i_out_stall | o_run_value, o_run_length,
//            |           |                         | o_encoded_length, o_overflow, o_last
//   cfg      | input     | psel/penable/pready     | paddr, pwdata, prdata
//
// One byte is accepted per clock while the op queue has room. The back end
// handles one closed run or final flush at a time, so a byte that both closes
// a run and ends the message needs two back-end steps; the queue absorbs it.
// An input byte's first item passes through the op queue and the output register.
// Reset is synchronous: run state, queue, byte count cleared; budget to 256.
// A stalled output holds its item; the front end keeps filling the queue and
// stalls the input once it is full.
`default_nettype none

module rle_byte_run_encoder_unit #(
    parameter int MAX_RUN     = 255,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic [rle_enc_pkg::BYTE_W-1:0]         i_data_byte,
    input  wire logic                                   i_final_byte,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic      [rle_enc_pkg::BYTE_W-1:0]         o_run_value,
    output logic      [rle_enc_pkg::RUN_LEN_W-1:0]      o_run_length,
    output logic      [rle_enc_pkg::LEN_W-1:0]          o_encoded_length,
    output logic                                        o_overflow,
    output logic                                        o_last,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [rle_enc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [rle_enc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [rle_enc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                        pready
);

    logic [rle_enc_pkg::LEN_W-1:0] budget;
    logic                          q_full;
    logic                          q_push;
    logic                          q_valid;
    rle_enc_pkg::t_run_op          push_entry;
    rle_enc_pkg::t_run_op          head_entry;
    rle_enc_pkg::t_q_ctl           q_ctl;

    rle_enc_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_budget (budget)
    );

    rle_enc_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_entry    (push_entry)
    );

    rle_enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_ctl.pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    rle_enc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_budget         (budget),
        .i_q_entry        (head_entry),
        .i_q_valid        (q_valid),
        .o_q_ctl          (q_ctl),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_run_value      (o_run_value),
        .o_run_length     (o_run_length),
        .o_encoded_length (o_encoded_length),
        .o_overflow       (o_overflow),
        .o_last           (o_last)
    );

    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_ctl.pop |-> q_ctl.valid)
        else $error("pop from empty queue");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> o_in_stall)
        else $error("input taken while queue full");

    a_no_push_unaccepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (i_in_valid && !o_in_stall))
        else $error("queue push without accepted item");

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for rle_byte_run_encoder_unit: byte messages in, run pairs out.
// Expected pairs are computed in-bench by a run-length predictor. Needs only rtl/.

module tb;

    localparam int BYTE_W     = rle_enc_pkg::BYTE_W;
    localparam int RUN_LEN_W  = rle_enc_pkg::RUN_LEN_W;
    localparam int LEN_W      = rle_enc_pkg::LEN_W;
    localparam int CFG_ADDR_W = rle_enc_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = rle_enc_pkg::CFG_DATA_W;

    localparam int RUN_CAP        = 255;
    localparam int SETTLE_CYCLES  = 12;
    localparam int TAIL_CYCLES    = 20;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 60;
    localparam logic [CFG_ADDR_W-1:0] BUDGET_ADDR =
        CFG_ADDR_W'(4 * rle_enc_pkg::REG_OUTPUT_BUDGET);

    typedef struct packed {
        logic [BYTE_W-1:0]    value;
        logic [RUN_LEN_W-1:0] count;
        logic [LEN_W-1:0]     enc_len;
        logic                 ovf;
        logic                 is_last;
    } t_pair;

    typedef enum logic {ROW_BYTE, ROW_BUDGET} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [LEN_W-1:0]  budget;
        logic [BYTE_W-1:0] data;
        logic              fin;
        logic              pinned;
        t_pair             want;
    } t_stim_row;

    localparam t_pair NO_PAIR = '0;
    localparam int N_ROWS = 27;

    // pinned rows carry their single expected pair; the rest go through the predictor
    localparam t_stim_row DIRECTED_ROWS [N_ROWS] = '{
        '{ROW_BYTE,   16'd0,     8'h00, 1'b1, 1'b1, '{8'h00, 8'd1, 16'd2, 1'b0, 1'b1}},
        '{ROW_BYTE,   16'd0,     8'hFF, 1'b1, 1'b1, '{8'hFF, 8'd1, 16'd2, 1'b0, 1'b1}},
        '{ROW_BYTE,   16'd0,     8'hAA, 1'b0, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'hAA, 1'b0, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'h55, 1'b1, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'hFF, 1'b0, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'hFF, 1'b0, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'hFF, 1'b0, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'h00, 1'b1, 1'b0, NO_PAIR},
        '{ROW_BUDGET, 16'd0,     8'h00, 1'b0, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'h5A, 1'b1, 1'b1, '{8'h00, 8'd0, 16'd0, 1'b1, 1'b1}},
        '{ROW_BUDGET, 16'd2,     8'h00, 1'b0, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'h01, 1'b0, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'h02, 1'b1, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'h03, 1'b0, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'h04, 1'b0, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'h05, 1'b1, 1'b0, NO_PAIR},
        '{ROW_BUDGET, 16'd4,     8'h00, 1'b0, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'h10, 1'b0, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'h11, 1'b0, 1'b0, NO_PAIR},
        // budget drops while a run is open: the flush now overflows
        '{ROW_BUDGET, 16'd2,     8'h00, 1'b0, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'h11, 1'b1, 1'b1, '{8'h00, 8'd0, 16'd2, 1'b1, 1'b1}},
        '{ROW_BUDGET, 16'hFFFF,  8'h00, 1'b0, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'h81, 1'b1, 1'b1, '{8'h81, 8'd1, 16'd2, 1'b0, 1'b1}},
        '{ROW_BUDGET, 16'd1,     8'h00, 1'b0, 1'b0, NO_PAIR},
        '{ROW_BYTE,   16'd0,     8'h7E, 1'b1, 1'b1, '{8'h00, 8'd0, 16'd0, 1'b1, 1'b1}},
        '{ROW_BUDGET, 16'd256,   8'h00, 1'b0, 1'b0, NO_PAIR}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [BYTE_W-1:0]     i_data_byte;
    logic                  i_final_byte;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [BYTE_W-1:0]     o_run_value;
    logic [RUN_LEN_W-1:0]  o_run_length;
    logic [LEN_W-1:0]      o_encoded_length;
    logic                  o_overflow;
    logic                  o_last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    rle_byte_run_encoder_unit #(.MAX_RUN(RUN_CAP)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_final_byte     (i_final_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_run_value      (o_run_value),
        .o_run_length     (o_run_length),
        .o_encoded_length (o_encoded_length),
        .o_overflow       (o_overflow),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [LEN_W-1:0]     budget_now   = rle_enc_pkg::BUDGET_RESET;
    logic [BYTE_W-1:0]    cur_byte     = '0;
    logic [RUN_LEN_W-1:0] cur_count    = '0;
    logic [LEN_W-1:0]     bytes_used   = '0;
    logic                 budget_blown = 1'b0;

    t_pair expected_pairs [$];
    t_pair step_pairs [$];

    int mismatches       = 0;
    int results_seen     = 0;
    int overflow_results = 0;
    int bytes_in         = 0;
    int messages         = 0;
    int budgets_written  = 0;
    int long_holds       = 0;
    int burst_left       = 0;
    int idle_cycles      = 0;
    bit sender_steady    = 1'b0;
    bit hold_request     = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] mismatch after %0d results: %s got %0h want %0h",
                 $time, results_seen, what, got, want);
    endtask

    function automatic void close_run(input logic [BYTE_W-1:0] v,
                                      input logic [RUN_LEN_W-1:0] n, input logic is_last);
        if (budget_blown)
            return;
        if (({1'b0, bytes_used} + {1'b0, rle_enc_pkg::PAIR_BYTES}) > {1'b0, budget_now}) begin
            budget_blown = 1'b1;
            return;
        end
        bytes_used += rle_enc_pkg::PAIR_BYTES;
        step_pairs.push_back(t_pair'{v, n, bytes_used, 1'b0, is_last});
    endfunction

    // pairs caused by one accepted byte land in step_pairs
    function automatic void encode_byte(input logic [BYTE_W-1:0] b, input logic fin);
        step_pairs.delete();
        if (cur_count != 0 && (b != cur_byte || cur_count >= RUN_CAP)) begin
            close_run(cur_byte, cur_count, 1'b0);
            cur_count = '0;
        end
        if (cur_count == 0) begin
            cur_byte  = b;
            cur_count = RUN_LEN_W'(1);
        end else begin
            cur_count++;
        end
        if (fin) begin
            close_run(cur_byte, cur_count, 1'b1);
            if (budget_blown)
                step_pairs.push_back(t_pair'{8'h00, 8'h00, bytes_used, 1'b1, 1'b1});
            cur_byte     = '0;
            cur_count    = '0;
            bytes_used   = '0;
            budget_blown = 1'b0;
        end
    endfunction

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fin,
                             input logic pinned, input t_pair pin);
        int gap;
        int k;
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (o_in_stall);
        bytes_in++;
        if (fin)
            messages++;
        encode_byte(b, fin);
        if (pinned)
            expected_pairs.push_back(pin);
        else
            for (k = 0; k < step_pairs.size(); k++)
                expected_pairs.push_back(step_pairs[k]);
        if (burst_left > 0) begin
            burst_left--;
        end else if (!sender_steady) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // always advances at least one edge so valid is never lowered and raised in one step
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_pairs.size() != 0);
    endtask

    task automatic set_budget(input logic [LEN_W-1:0] v);
        logic [CFG_DATA_W-1:0] rd;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BUDGET_ADDR;
        pwdata  <= CFG_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        budget_now = v;
        budgets_written++;
        // read back, psel stays high into the next setup cycle
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== CFG_DATA_W'(v))
            report_mismatch("budget readback", rd, CFG_DATA_W'(v));
    endtask

    function automatic logic [BYTE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(0, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_message(input int max_len);
        int len;
        int run;
        int sent;
        int k;
        logic [BYTE_W-1:0] v;
        len  = $urandom_range(1, max_len);
        sent = 0;
        while (sent < len) begin
            v = pick_value();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: run = 1;
                9:             run = $urandom_range(2, 40);
                default:       run = $urandom_range(2, 12);
            endcase
            for (k = 0; k < run && sent < len; k++) begin
                push_byte(v, sent == len - 1, 1'b0, NO_PAIR);
                sent++;
            end
        end
    endtask

    task automatic send_long_run(input int len);
        int k;
        logic [BYTE_W-1:0] v;
        v = 8'($urandom);
        for (k = 0; k < len; k++)
            push_byte(v, k == len - 1, 1'b0, NO_PAIR);
    endtask

    // receiver: stall patterns in segments, plus one long hold-off on request
    initial begin : rx_side
        int seg_left;
        int mode;
        int hold_left;
        int tick;
        int period;
        int open_len;
        bit hold_done;
        seg_left  = 0;
        mode      = 0;
        hold_left = 0;
        tick      = 0;
        period    = 2;
        open_len  = 1;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                long_holds++;
            end
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(20, 200);
                period   = $urandom_range(2, 16);
                open_len = $urandom_range(1, period - 1);
            end
            seg_left--;
            tick++;
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 99) < 30);
                    2:       i_out_stall <= ($urandom_range(0, 99) < 75);
                    default: i_out_stall <= ((tick % period) >= open_len);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_pair want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pairs.size() == 0) begin
                report_mismatch("unexpected result, value", 32'(o_run_value), 32'd0);
            end else begin
                want = expected_pairs.pop_front();
                if (o_run_value !== want.value)
                    report_mismatch("run_value", 32'(o_run_value), 32'(want.value));
                if (o_run_length !== want.count)
                    report_mismatch("run_length", 32'(o_run_length), 32'(want.count));
                if (o_encoded_length !== want.enc_len)
                    report_mismatch("encoded_length", 32'(o_encoded_length),
                                    32'(want.enc_len));
                if (o_overflow !== want.ovf)
                    report_mismatch("overflow", 32'(o_overflow), 32'(want.ovf));
                if (o_last !== want.is_last)
                    report_mismatch("last", 32'(o_last), 32'(want.is_last));
            end
            results_seen++;
            if (o_overflow === 1'b1)
                overflow_results++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] no progress for %0d cycles", $time, idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int r;
        int p;
        int k;
        int phase_start;
        logic [LEN_W-1:0] phase_budget [8];
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_data_byte  <= '0;
        i_final_byte <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < N_ROWS; r++) begin
            if (DIRECTED_ROWS[r].kind == ROW_BUDGET)
                set_budget(DIRECTED_ROWS[r].budget);
            else
                push_byte(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].fin,
                          DIRECTED_ROWS[r].pinned, DIRECTED_ROWS[r].want);
        end

        phase_budget = '{16'hFFFF, 16'd0, 16'd1, 16'd2, LEN_W'($urandom_range(3, 40)),
                         rle_enc_pkg::BUDGET_RESET, LEN_W'($urandom),
                         LEN_W'($urandom_range(4, 24))};
        for (p = 0; p < 8; p++) begin
            set_budget(phase_budget[p]);
            phase_start = bytes_in;
            if (p == 0) begin
                // output held off while input keeps coming: queue fills, input stalls
                sender_steady = 1'b1;
                hold_request  = 1'b1;
                for (k = 0; k < 10; k++)
                    send_message(12);
                sender_steady = 1'b0;
                // runs at and past the cap
                send_long_run(255);
                send_long_run(256);
                send_long_run(511);
            end
            while (bytes_in - phase_start < PHASE_ITEMS) begin
                send_message(($urandom_range(0, 3) == 0) ? 40 : 10);
                if ($urandom_range(0, 19) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_pairs.size() != 0)
            report_mismatch("results never seen", 32'(expected_pairs.size()), 32'd0);

        $display("covered %0d bytes in %0d messages, %0d pairs out (%0d overflow)",
                 bytes_in, messages, results_seen, overflow_results);
        $display("budget writes %0d incl. 0, 1, 2 and 65535; long output hold-offs %0d",
                 budgets_written, long_holds);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
